// ===== sv/prime_field_alu_defines.svh =====
// assertion macros for the prime field alu
// expects clk_i and rst_ni in the scope where a macro is used
`ifndef PRIME_FIELD_ALU_DEFINES_SVH
`define PRIME_FIELD_ALU_DEFINES_SVH

// property holds on every clock edge out of reset
`define PFA_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) else $error(msg);

// condition never seen on a clock edge out of reset
`define PFA_ASSERT_NEVER(lbl, cond, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) !(cond)) else $error(msg);

`endif

// ===== sv/pfa_pkg.sv =====
// types and constants of the prime field alu
// no dependencies
`default_nettype none

package pfa_pkg;

  localparam int unsigned FIELD_W = 16;

  localparam logic [FIELD_W-1:0] MODULUS_RESET = 16'd65521;

  // operation codes
  localparam logic [2:0] OP_ADD = 3'd0;
  localparam logic [2:0] OP_SUB = 3'd1;
  localparam logic [2:0] OP_NEG = 3'd2;
  localparam logic [2:0] OP_MUL = 3'd3;
  localparam logic [2:0] OP_DIV = 3'd4;

  typedef struct packed {
    logic [2:0]         operation;
    logic [FIELD_W-1:0] operand_a;
    logic [FIELD_W-1:0] operand_b;
  } pfa_in_t;

  typedef struct packed {
    logic [FIELD_W-1:0] result_value;
    logic               divide_by_zero;
    logic               operands_equal;
    logic               a_is_zero;
  } pfa_out_t;

endpackage

`default_nettype wire

// ===== sv/prime_field_alu.sv =====
// top level of the prime field alu: sequencer, modulus register, result register
// depends on pfa_pkg, pfa_mulmod, pfa_inverse and prime_field_alu_defines.svh
`default_nettype none
`include "prime_field_alu_defines.svh"

// One operation in the integers modulo p per item, p held in the modulus
// register (reset 65521, only its low VALUE_WIDTH bits count). A beat is taken
// when start is high and busy is low; if p is at least 2, busy then stays high
// until the result beat, which sits on result_o for exactly one cycle with
// result_valid_o high. The receiver cannot stall: a result that is not taken
// in that cycle is gone. Both operands are reduced first by two bit-serial
// reduction lanes, one bit a cycle. Add, subtract and negate then compute on
// the reduced operands and register the result; multiply adds a bit-serial
// pass of the shared multiplier. Divide runs the extended euclid unit between
// reduction and multiply. A divide whose b reduces to zero returns as fast as
// an add; one with no inverse returns right after the euclid unit, skipping
// the multiply. With p below 2 every operand is zero and the result comes in
// the cycle after start. busy is low in the cycle of the result beat, so the
// next item may start there. The modulus port is always ready and may be
// written only while idle.

module prime_field_alu #(
  parameter int unsigned VALUE_WIDTH = 16
) (
  input  logic            clk_i,
  input  logic            rst_ni,
  // item channel
  input  logic            start,
  output logic            busy,
  input  pfa_pkg::pfa_in_t  item_i,
  // result channel
  output logic            result_valid_o,
  output pfa_pkg::pfa_out_t result_o,
  // modulus write channel
  input  logic            cfg_valid_i,
  output logic            cfg_ready_o,
  input  logic [15:0]     cfg_data_i
);

  import pfa_pkg::*;

  localparam int unsigned W = VALUE_WIDTH;

  typedef enum logic [2:0] {
    S_IDLE,
    S_REDUCE,
    S_ALU,
    S_INV,
    S_MUL
  } alu_state_e;

  alu_state_e         state_q;
  logic [FIELD_W-1:0] modulus_q;
  logic [2:0]         op_q;
  logic [W-1:0]       a_q, b_q;
  pfa_out_t           out_q;
  logic               strobe_q;

  // field widths versus internal width: zero extend then slice
  logic [W+FIELD_W-1:0] p_ext, a_in_ext, b_in_ext, fin_ext;
  logic [W-1:0]         p_w, a_in, b_in;
  logic                 p_ok;
  logic                 accept;

  assign p_ext    = {{W{1'b0}}, modulus_q};
  assign a_in_ext = {{W{1'b0}}, item_i.operand_a};
  assign b_in_ext = {{W{1'b0}}, item_i.operand_b};
  assign p_w      = p_ext[W-1:0];
  assign a_in     = a_in_ext[W-1:0];
  assign b_in     = b_in_ext[W-1:0];
  assign p_ok     = p_w > W'(1);

  assign busy        = (state_q != S_IDLE);
  assign accept      = start && !busy;
  assign cfg_ready_o = 1'b1;

  // reduction lanes: x mod p as 1 * x through the serial multiplier
  logic         red_start;
  logic         red_a_done, red_b_done;
  logic [W-1:0] red_a, red_b;

  assign red_start = accept && p_ok;

  pfa_mulmod #(.W(W)) u_red_a (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (red_start),
    .p_i     (p_w),
    .x_i     (W'(1)),
    .y_i     (a_in),
    .done_o  (red_a_done),
    .prod_o  (red_a)
  );

  pfa_mulmod #(.W(W)) u_red_b (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (red_start),
    .p_i     (p_w),
    .x_i     (W'(1)),
    .y_i     (b_in),
    .done_o  (red_b_done),
    .prod_o  (red_b)
  );

  // inverse of b for divide
  logic         inv_start, inv_done, inv_ok;
  logic [W-1:0] inv_val;

  assign inv_start = (state_q == S_ALU) && (op_q == OP_DIV) && (b_q != '0);

  pfa_inverse #(.W(W)) u_inverse (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (inv_start),
    .p_i     (p_w),
    .b_i     (b_q),
    .done_o  (inv_done),
    .ok_o    (inv_ok),
    .inv_o   (inv_val)
  );

  // shared multiplier: a * b for multiply, a * inverse for divide
  logic         mul_start, mul_done;
  logic [W-1:0] mul_y, mul_res;

  assign mul_start = ((state_q == S_ALU) && (op_q == OP_MUL)) ||
                     ((state_q == S_INV) && inv_done && inv_ok);
  assign mul_y     = (state_q == S_INV) ? inv_val : b_q;

  pfa_mulmod #(.W(W)) u_mul (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (mul_start),
    .p_i     (p_w),
    .x_i     (a_q),
    .y_i     (mul_y),
    .done_o  (mul_done),
    .prod_o  (mul_res)
  );

  // combinational ops on reduced operands
  logic [W:0]   sum;
  logic [W-1:0] add_res, sub_res, neg_res;

  assign sum     = {1'b0, a_q} + {1'b0, b_q};
  assign add_res = (sum >= {1'b0, p_w}) ? W'(sum - {1'b0, p_w}) : sum[W-1:0];
  // wraps in W bits, true value is below p
  assign sub_res = (a_q < b_q) ? (a_q - b_q + p_w) : (a_q - b_q);
  assign neg_res = (a_q == '0) ? '0 : (p_w - a_q);

  // result of whatever finishes this cycle
  logic [W-1:0] fin_val;
  logic         fin_dbz;
  pfa_out_t     fin_out;
  pfa_out_t     small_out;

  always_comb begin
    fin_val = '0;
    fin_dbz = 1'b0;
    unique case (state_q)
      S_ALU: begin
        unique case (op_q)
          OP_ADD:  fin_val = add_res;
          OP_SUB:  fin_val = sub_res;
          OP_NEG:  fin_val = neg_res;
          OP_DIV:  fin_dbz = 1'b1;
          default: fin_val = '0;
        endcase
      end
      S_INV:   fin_dbz = 1'b1;
      S_MUL:   fin_val = mul_res;
      default: fin_val = '0;
    endcase
  end

  assign fin_ext                = {{FIELD_W{1'b0}}, fin_val};
  assign fin_out.result_value   = fin_ext[FIELD_W-1:0];
  assign fin_out.divide_by_zero = fin_dbz;
  assign fin_out.operands_equal = (a_q == b_q);
  assign fin_out.a_is_zero      = (a_q == '0);

  // p below 2: both operands reduce to zero
  assign small_out.result_value   = '0;
  assign small_out.divide_by_zero = (item_i.operation == OP_DIV);
  assign small_out.operands_equal = 1'b1;
  assign small_out.a_is_zero      = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= S_IDLE;
      strobe_q  <= 1'b0;
      modulus_q <= MODULUS_RESET;
    end else begin
      strobe_q <= 1'b0;
      if (cfg_valid_i && cfg_ready_o) begin
        modulus_q <= cfg_data_i;
      end
      unique case (state_q)
        S_IDLE: begin
          if (accept) begin
            op_q <= item_i.operation;
            if (p_ok) begin
              state_q <= S_REDUCE;
            end else begin
              out_q    <= small_out;
              strobe_q <= 1'b1;
            end
          end
        end
        S_REDUCE: begin
          if (red_a_done && red_b_done) begin
            a_q     <= red_a;
            b_q     <= red_b;
            state_q <= S_ALU;
          end
        end
        S_ALU: begin
          if (op_q == OP_MUL) begin
            state_q <= S_MUL;
          end else if (inv_start) begin
            state_q <= S_INV;
          end else begin
            out_q    <= fin_out;
            strobe_q <= 1'b1;
            state_q  <= S_IDLE;
          end
        end
        S_INV: begin
          if (inv_done) begin
            if (inv_ok) begin
              state_q <= S_MUL;
            end else begin
              // b shares a factor with p, no inverse
              out_q    <= fin_out;
              strobe_q <= 1'b1;
              state_q  <= S_IDLE;
            end
          end
        end
        S_MUL: begin
          if (mul_done) begin
            out_q    <= fin_out;
            strobe_q <= 1'b1;
            state_q  <= S_IDLE;
          end
        end
        default: state_q <= S_IDLE;
      endcase
    end
  end

  assign result_valid_o = strobe_q;
  assign result_o       = out_q;

  // range check of a delivered result against the modulus
  logic [W+FIELD_W-1:0] res_chk, p_chk;

  assign res_chk = {{W{1'b0}}, result_o.result_value};
  assign p_chk   = {{FIELD_W{1'b0}}, p_w};

  `PFA_ASSERT_NEVER(a_strobe_while_busy, result_valid_o && busy, "result beat while busy")
  `PFA_ASSERT(a_small_modulus_fast, accept && !p_ok |=> result_valid_o, "p below 2 not immediate")
  `PFA_ASSERT(a_dbz_only_divide, result_valid_o && result_o.divide_by_zero |-> op_q == OP_DIV, "dbz without divide")
  `PFA_ASSERT(a_result_in_field, result_valid_o && p_ok |-> res_chk < p_chk, "result not below p")
  `PFA_ASSERT_NEVER(a_mul_start_busy, mul_start && (state_q == S_MUL), "multiplier restarted")

endmodule

`default_nettype wire

// ===== sv/pfa_mulmod.sv =====
// bit-serial modular multiplier, msb first double-and-add, one bit per cycle
// standalone, no package; x_i must be below p_i and held while busy
`default_nettype none

module pfa_mulmod #(
  parameter int unsigned W = 16
) (
  input  logic         clk_i,
  input  logic         rst_ni,
  input  logic         start_i,
  input  logic [W-1:0] p_i,
  input  logic [W-1:0] x_i,
  input  logic [W-1:0] y_i,
  output logic         done_o,
  output logic [W-1:0] prod_o
);

  localparam int unsigned CW = $clog2(W);

  logic          busy_q;
  logic          done_q;
  logic [CW-1:0] cnt_q;
  logic [W-1:0]  acc_q, acc_d;
  logic [W-1:0]  y_q;

  logic [W+1:0]  v, v1, v2, p1, p2;

  // 2*acc + bit*x stays below 3p, so at most two subtractions of p
  assign p1 = {2'b00, p_i};
  assign p2 = {1'b0, p_i, 1'b0};
  assign v  = {1'b0, acc_q, 1'b0} + (y_q[W-1] ? {2'b00, x_i} : '0);
  assign v1 = v - p1;
  assign v2 = v - p2;

  always_comb begin
    if (v >= p2) begin
      acc_d = v2[W-1:0];
    end else if (v >= p1) begin
      acc_d = v1[W-1:0];
    end else begin
      acc_d = v[W-1:0];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= 1'b0;
      if (!busy_q) begin
        if (start_i) begin
          busy_q <= 1'b1;
          cnt_q  <= CW'(W - 1);
        end
      end else begin
        cnt_q <= cnt_q - 1'b1;
        if (cnt_q == '0) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (!busy_q && start_i) begin
      acc_q <= '0;
      y_q   <= y_i;
    end else if (busy_q) begin
      acc_q <= acc_d;
      y_q   <= {y_q[W-2:0], 1'b0};
    end
  end

  assign done_o = done_q;
  assign prod_o = acc_q;

endmodule

`default_nettype wire

// ===== sv/pfa_inverse.sv =====
// modular inverse by extended euclid, quotients found by shift and subtract
// standalone, no package; b_i nonzero and below p_i, p_i at least 2
`default_nettype none

module pfa_inverse #(
  parameter int unsigned W = 16
) (
  input  logic         clk_i,
  input  logic         rst_ni,
  input  logic         start_i,
  input  logic [W-1:0] p_i,
  input  logic [W-1:0] b_i,
  output logic         done_o,
  output logic         ok_o,
  output logic [W-1:0] inv_o
);

  // bezout coefficients stay within +-p, shifted ones within +-2p
  localparam int unsigned TW = W + 3;
  localparam int unsigned KW = $clog2(W);

  typedef enum logic [2:0] {
    I_IDLE,
    I_CHECK,
    I_ALIGN,
    I_SUB,
    I_FIX
  } inv_state_e;

  inv_state_e           state_q;
  logic                 done_q;
  logic                 ok_q;
  logic [W-1:0]         inv_q;
  logic [W-1:0]         r0_q, r1_q;
  logic [W:0]           d_q;
  logic signed [TW-1:0] t0_q, t1_q, e_q;
  logic [KW-1:0]        k_q;

  logic                 dbl_fits, sub_fits;
  logic [W-1:0]         r0_sub;
  logic signed [TW-1:0] t0_sub, p_t, t_fix;

  assign p_t      = $signed({{(TW-W){1'b0}}, p_i});
  assign dbl_fits = {d_q, 1'b0} <= {2'b00, r0_q};
  assign sub_fits = d_q <= {1'b0, r0_q};
  assign r0_sub   = r0_q - d_q[W-1:0];
  assign t0_sub   = t0_q - e_q;

  always_comb begin
    if (t0_q < 0) begin
      t_fix = t0_q + p_t;
    end else if (t0_q >= p_t) begin
      t_fix = t0_q - p_t;
    end else begin
      t_fix = t0_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= I_IDLE;
      done_q  <= 1'b0;
      ok_q    <= 1'b0;
      k_q     <= '0;
    end else begin
      done_q <= 1'b0;
      unique case (state_q)
        I_IDLE: begin
          if (start_i) begin
            r0_q    <= p_i;
            r1_q    <= b_i;
            t0_q    <= '0;
            t1_q    <= {{(TW-1){1'b0}}, 1'b1};
            state_q <= I_CHECK;
          end
        end
        I_CHECK: begin
          if (r1_q == '0) begin
            state_q <= I_FIX;
          end else begin
            d_q     <= {1'b0, r1_q};
            e_q     <= t1_q;
            k_q     <= '0;
            state_q <= I_ALIGN;
          end
        end
        I_ALIGN: begin
          if (dbl_fits) begin
            d_q <= {d_q[W-1:0], 1'b0};
            e_q <= e_q <<< 1;
            k_q <= k_q + 1'b1;
          end else begin
            state_q <= I_SUB;
          end
        end
        I_SUB: begin
          if (k_q == '0) begin
            // remainder and new coefficient rotate into place
            r0_q    <= r1_q;
            t0_q    <= t1_q;
            r1_q    <= sub_fits ? r0_sub : r0_q;
            t1_q    <= sub_fits ? t0_sub : t0_q;
            state_q <= I_CHECK;
          end else begin
            if (sub_fits) begin
              r0_q <= r0_sub;
              t0_q <= t0_sub;
            end
            d_q <= {1'b0, d_q[W:1]};
            e_q <= e_q >>> 1;
            k_q <= k_q - 1'b1;
          end
        end
        I_FIX: begin
          ok_q    <= (r0_q == W'(1));
          inv_q   <= t_fix[W-1:0];
          done_q  <= 1'b1;
          state_q <= I_IDLE;
        end
        default: state_q <= I_IDLE;
      endcase
    end
  end

  assign done_o = done_q;
  assign ok_o   = ok_q;
  assign inv_o  = inv_q;

endmodule

`default_nettype wire
